// ----- sv/air_quality_fan_mist_controller_unit_assert.svh -----
// Assertion macros for the air quality fan and mist controller.
// Included by the top level; depends on nothing else.
`ifndef AIR_QUALITY_FAN_MIST_CONTROLLER_UNIT_ASSERT_SVH
`define AIR_QUALITY_FAN_MIST_CONTROLLER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define AQFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aqfm assertion failed");
// Next-cycle implication, disabled during reset.
`define AQFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aqfm assertion failed");
`else
`define AQFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define AQFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/aqfm_pkg.sv -----
// Shared types, codes and constants of the air quality fan and mist controller.
// Used by every module of the block; depends on nothing.
package aqfm_pkg;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_EVAL     = 2'd0,
        KIND_SET_AUTO = 2'd1,
        KIND_SET_FAN  = 2'd2,
        KIND_SET_MIST = 2'd3
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DUST_HIGH = 3'd0,
        CFG_DUST_MED  = 3'd1,
        CFG_GAS_HIGH  = 3'd2,
        CFG_GAS_MED   = 3'd3,
        CFG_TEMP_HIGH = 3'd4,
        CFG_HUM_LOW   = 3'd5,
        CFG_HOLD_TOP  = 3'd6,
        CFG_HOLD_MID  = 3'd7
    } t_cfg_idx;

    // Pollution levels.
    localparam logic [1:0] LVL_GREEN  = 2'd0;
    localparam logic [1:0] LVL_YELLOW = 2'd2;
    localparam logic [1:0] LVL_RED    = 2'd3;

    // Fan levels.
    localparam logic [1:0] FAN_OFF  = 2'd0;
    localparam logic [1:0] FAN_LOW  = 2'd1;
    localparam logic [1:0] FAN_MID  = 2'd2;
    localparam logic [1:0] FAN_HIGH = 2'd3;

    // Alarm beep counts.
    localparam logic [1:0] BEEP_NONE   = 2'd0;
    localparam logic [1:0] BEEP_ACK    = 2'd1;
    localparam logic [1:0] BEEP_AUTO   = 2'd2;
    localparam logic [1:0] BEEP_ALARM  = 2'd3;

    // Inverted PWM duty per fan level.
    localparam logic [7:0] DUTY_OFF  = 8'd255;
    localparam logic [7:0] DUTY_LOW  = 8'd77;
    localparam logic [7:0] DUTY_MID  = 8'd39;
    localparam logic [7:0] DUTY_HIGH = 8'd0;

    // Configuration reset values.
    localparam logic [15:0]        RST_DUST_HIGH = 16'd150;
    localparam logic [15:0]        RST_DUST_MED  = 16'd75;
    localparam logic [15:0]        RST_GAS_HIGH  = 16'd800;
    localparam logic [15:0]        RST_GAS_MED   = 16'd400;
    localparam logic signed [11:0] RST_TEMP_HIGH = 12'sd350;
    localparam logic [9:0]         RST_HUM_LOW   = 10'd600;
    localparam logic [15:0]        RST_HOLD_TOP  = 16'd30000;
    localparam logic [15:0]        RST_HOLD_MID  = 16'd20000;

    localparam logic [15:0] MS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0]        dust_high;
        logic [15:0]        dust_med;
        logic [15:0]        gas_high;
        logic [15:0]        gas_med;
        logic signed [11:0] temp_high;
        logic [9:0]         hum_low;
        logic [15:0]        hold_top_ms;
        logic [15:0]        hold_mid_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         value;
        logic [15:0]        dust_ug;
        logic [15:0]        gas_ppm;
        logic signed [11:0] temp_tenths;
        logic [9:0]         hum_tenths;
        logic               tank_low;
        logic [15:0]        elapsed_ms;
    } t_item;

    typedef struct packed {
        logic [1:0] pollution_level;
        logic [1:0] fan_speed;
        logic       fan_relay;
        logic [7:0] fan_duty;
        logic       mist_relay;
        logic [1:0] beeps;
        logic       auto_flag;
    } t_result;

    // Duty lookup for an applied fan level.
    function automatic logic [7:0] duty_of(input logic [1:0] lvl);
        logic [7:0] d;
        case (lvl)
            FAN_OFF: d = DUTY_OFF;
            FAN_LOW: d = DUTY_LOW;
            FAN_MID: d = DUTY_MID;
            default: d = DUTY_HIGH;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/aqfm_eval.sv -----
// Sensor evaluation: pollution level and automatic mist request.
// Depends on aqfm_pkg.
module aqfm_eval
    import aqfm_pkg::*;
(
    input  t_cfg               i_cfg,
    input  logic [15:0]        i_dust_ug,
    input  logic [15:0]        i_gas_ppm,
    input  logic signed [11:0] i_temp_tenths,
    input  logic [9:0]         i_hum_tenths,
    output logic [1:0]         o_level,
    output logic               o_mist_req
);

    // High thresholds win over medium ones.
    always_comb begin
        if (i_dust_ug > i_cfg.dust_high || i_gas_ppm > i_cfg.gas_high) begin
            o_level = LVL_RED;
        end else if (i_dust_ug > i_cfg.dust_med || i_gas_ppm > i_cfg.gas_med) begin
            o_level = LVL_YELLOW;
        end else begin
            o_level = LVL_GREEN;
        end
    end

    // Mist is wanted when hot, or when dry with a real (nonzero) humidity reading.
    assign o_mist_req = ($signed(i_temp_tenths) > $signed(i_cfg.temp_high)) ||
                        ((i_hum_tenths < i_cfg.hum_low) && (i_hum_tenths != 10'd0));

endmodule

// ----- sv/aqfm_state.sv -----
// Controller state and its per-word update: fan dwell, mode and mist.
// Depends on aqfm_pkg and aqfm_eval.
module aqfm_state
    import aqfm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_res
);

    logic        r_auto_on,   n_auto_on;
    logic [1:0]  r_wanted,    n_wanted;
    logic [1:0]  r_applied,   n_applied;
    logic [15:0] r_since,     n_since;
    logic [1:0]  r_last,      n_last;
    logic        r_mist,      n_mist;

    logic [1:0]  lvl;
    logic        mist_req;
    logic [16:0] since_sum;
    logic [15:0] since_sat;
    logic [1:0]  beeps;
    logic        go;

    aqfm_eval u_eval (
        .i_cfg         (i_cfg),
        .i_dust_ug     (i_item.dust_ug),
        .i_gas_ppm     (i_item.gas_ppm),
        .i_temp_tenths (i_item.temp_tenths),
        .i_hum_tenths  (i_item.hum_tenths),
        .o_level       (lvl),
        .o_mist_req    (mist_req)
    );

    // Saturating dwell counter; every word adds its elapsed time.
    assign since_sum = {1'b0, r_since} + {1'b0, i_item.elapsed_ms};
    assign since_sat = since_sum[16] ? MS_MAX : since_sum[15:0];

    // Next state for the word in the input register.
    always_comb begin
        n_auto_on = r_auto_on;
        n_wanted  = r_wanted;
        n_applied = r_applied;
        n_since   = since_sat;
        n_last    = r_last;
        n_mist    = r_mist;
        beeps     = BEEP_NONE;
        go        = 1'b0;
        unique case (t_kind'(i_item.kind))
            KIND_EVAL: begin
                n_last = lvl;
                if (r_auto_on) begin
                    n_wanted = lvl;
                    if (lvl == LVL_RED && r_last != LVL_RED) begin
                        beeps = BEEP_ALARM;
                    end
                end
                // Step up, or any manual change, at once; step down from the top two levels after the dwell.
                if (n_wanted != r_applied) begin
                    if (!r_auto_on || n_wanted > r_applied) begin
                        go = 1'b1;
                    end else if (r_applied == FAN_HIGH) begin
                        go = since_sat >= i_cfg.hold_top_ms;
                    end else if (r_applied == FAN_MID) begin
                        go = since_sat >= i_cfg.hold_mid_ms;
                    end else begin
                        go = 1'b1;
                    end
                end
                if (go) begin
                    n_applied = n_wanted;
                    n_since   = '0;
                end
                if (i_item.tank_low) begin
                    n_mist = 1'b0;
                end else if (r_auto_on) begin
                    n_mist = mist_req;
                end
            end
            KIND_SET_AUTO: begin
                n_auto_on = (i_item.value != 2'd0);
                if (n_auto_on) begin
                    beeps     = BEEP_AUTO;
                    n_wanted  = FAN_OFF;
                    n_applied = FAN_OFF;
                end else begin
                    beeps = BEEP_ACK;
                end
            end
            KIND_SET_FAN: begin
                if (!r_auto_on) begin
                    n_wanted = i_item.value;
                    beeps    = BEEP_ACK;
                end
            end
            KIND_SET_MIST: begin
                if (!r_auto_on) begin
                    n_mist = (i_item.value != 2'd0);
                    beeps  = BEEP_ACK;
                end
            end
            default: begin
                n_auto_on = r_auto_on;
            end
        endcase
    end

    // Result word reflects the state after this word.
    always_comb begin
        o_res.pollution_level = n_last;
        o_res.fan_speed       = n_applied;
        o_res.fan_relay       = (n_applied != FAN_OFF);
        o_res.fan_duty        = duty_of(n_applied);
        o_res.mist_relay      = n_mist;
        o_res.beeps           = beeps;
        o_res.auto_flag       = n_auto_on;
    end

    // State registers advance only when a word moves to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_on <= 1'b1;
            r_wanted  <= FAN_OFF;
            r_applied <= FAN_OFF;
            r_since   <= '0;
            r_last    <= LVL_GREEN;
            r_mist    <= 1'b0;
        end else if (i_en) begin
            r_auto_on <= n_auto_on;
            r_wanted  <= n_wanted;
            r_applied <= n_applied;
            r_since   <= n_since;
            r_last    <= n_last;
            r_mist    <= n_mist;
        end
    end

endmodule

// ----- sv/air_quality_fan_mist_controller_unit.sv -----
// Top level of the air quality fan and mist controller: input register,
// configuration registers, output register and assertions.
// Depends on aqfm_pkg, aqfm_state and the assertion macro header.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------------
//   input   | i_in_valid / o_in_ready   | i_kind .. i_elapsed_ms
//   output  | o_out_valid / i_out_ready | o_pollution_level .. o_auto_flag
//   config  | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A word is held in the input register, where the state update runs, and then sits
// in the output register; one word per cycle moves through while the output does not stall.
// The rate is set by the state update, which is combinational between the two registers.
// Reset is synchronous and active low; it loads the default thresholds and state.
// While the output word is stalled the input register still takes one more word.
`include "air_quality_fan_mist_controller_unit_assert.svh"

module air_quality_fan_mist_controller_unit
    import aqfm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [1:0]         i_value,
    input  logic [15:0]        i_dust_ug,
    input  logic [15:0]        i_gas_ppm,
    input  logic signed [11:0] i_temp_tenths,
    input  logic [9:0]         i_hum_tenths,
    input  logic               i_tank_low,
    input  logic [15:0]        i_elapsed_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_pollution_level,
    output logic [1:0]         o_fan_speed,
    output logic               o_fan_relay,
    output logic [7:0]         o_fan_duty,
    output logic               o_mist_relay,
    output logic [1:0]         o_beeps,
    output logic               o_auto_flag,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_res;
    logic    r_out_valid;
    t_result res;
    logic    advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dust_high   <= RST_DUST_HIGH;
            r_cfg.dust_med    <= RST_DUST_MED;
            r_cfg.gas_high    <= RST_GAS_HIGH;
            r_cfg.gas_med     <= RST_GAS_MED;
            r_cfg.temp_high   <= RST_TEMP_HIGH;
            r_cfg.hum_low     <= RST_HUM_LOW;
            r_cfg.hold_top_ms <= RST_HOLD_TOP;
            r_cfg.hold_mid_ms <= RST_HOLD_MID;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DUST_HIGH: r_cfg.dust_high   <= i_cfg_data;
                CFG_DUST_MED:  r_cfg.dust_med    <= i_cfg_data;
                CFG_GAS_HIGH:  r_cfg.gas_high    <= i_cfg_data;
                CFG_GAS_MED:   r_cfg.gas_med     <= i_cfg_data;
                CFG_TEMP_HIGH: r_cfg.temp_high   <= $signed(i_cfg_data[11:0]);
                CFG_HUM_LOW:   r_cfg.hum_low     <= i_cfg_data[9:0];
                CFG_HOLD_TOP:  r_cfg.hold_top_ms <= i_cfg_data;
                CFG_HOLD_MID:  r_cfg.hold_mid_ms <= i_cfg_data;
                default:       r_cfg.dust_high   <= r_cfg.dust_high;
            endcase
        end
    end

    // The word in the input register moves on when the output register frees up.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.kind        <= i_kind;
            r_in.value       <= i_value;
            r_in.dust_ug     <= i_dust_ug;
            r_in.gas_ppm     <= i_gas_ppm;
            r_in.temp_tenths <= i_temp_tenths;
            r_in.hum_tenths  <= i_hum_tenths;
            r_in.tank_low    <= i_tank_low;
            r_in.elapsed_ms  <= i_elapsed_ms;
        end
    end

    aqfm_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_res   (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pollution_level = r_res.pollution_level;
    assign o_fan_speed       = r_res.fan_speed;
    assign o_fan_relay       = r_res.fan_relay;
    assign o_fan_duty        = r_res.fan_duty;
    assign o_mist_relay      = r_res.mist_relay;
    assign o_beeps           = r_res.beeps;
    assign o_auto_flag       = r_res.auto_flag;

    // Relay and duty of a result word agree with its fan level.
    `AQFM_ASSERT_NOW(a_fan_consistent, i_clk, i_rst_n, r_out_valid, (o_fan_relay == (o_fan_speed != FAN_OFF)) && (o_fan_duty == duty_of(o_fan_speed)))
    // The alarm only sounds in automatic mode at the red level.
    `AQFM_ASSERT_NOW(a_alarm_red, i_clk, i_rst_n, r_out_valid && (o_beeps == BEEP_ALARM), (o_pollution_level == LVL_RED) && o_auto_flag)
    // A full input register behind a stalled output word takes nothing more.
    `AQFM_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, r_in_valid && r_out_valid && !i_out_ready, !o_in_ready)
    // A word that moves on always shows up as a valid result next cycle.
    `AQFM_ASSERT_NEXT(a_advance_out, i_clk, i_rst_n, advance, r_out_valid)

endmodule

// ----- bench/air_quality_fan_mist_controller_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the air quality fan and mist controller: a directed table, then
// random words under several threshold settings, checked against an in-bench status model.
// Depends on aqfm_pkg and the air_quality_fan_mist_controller_unit top level.
module air_quality_fan_mist_controller_unit_test;
    import aqfm_pkg::*;

    localparam int TEMP_MIN        = -400;
    localparam int TEMP_MAX        = 1250;
    localparam int HUM_MAX         = 1000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        t_item   word;
        logic    typed;
        t_result status;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_kind;
    logic [1:0]         i_value;
    logic [15:0]        i_dust_ug;
    logic [15:0]        i_gas_ppm;
    logic signed [11:0] i_temp_tenths;
    logic [9:0]         i_hum_tenths;
    logic               i_tank_low;
    logic [15:0]        i_elapsed_ms;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_pollution_level;
    logic [1:0]         o_fan_speed;
    logic               o_fan_relay;
    logic [7:0]         o_fan_duty;
    logic               o_mist_relay;
    logic [1:0]         o_beeps;
    logic               o_auto_flag;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    // Status model: its own copy of the thresholds and of the controller state.
    t_cfg       cfg_model;
    logic       ctl_auto;
    logic [1:0] ctl_wanted;
    logic [1:0] ctl_applied;
    logic [15:0] ctl_dwell;
    logic [1:0] ctl_level;
    logic       ctl_mist;
    logic [7:0] ctl_duty;

    t_result pending_status [$];
    t_row    directed_rows [$];
    logic    word_typed;
    t_result word_status;
    int      sender_idle_pct;
    int      receiver_idle_pct;
    logic    choke_request;
    int      mismatches;
    int      cycles;

    air_quality_fan_mist_controller_unit uut (.*);

    // Free-running 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Works out the status word that one input word produces and advances the model.
    function automatic t_result predict_status(input t_item w);
        t_result     r;
        logic [16:0] sum;
        logic [1:0]  beeps;
        logic        step;
        beeps = BEEP_NONE;
        step = 1'b1;
        sum = {1'b0, ctl_dwell} + {1'b0, w.elapsed_ms};
        ctl_dwell = sum[16] ? MS_MAX : sum[15:0];
        case (t_kind'(w.kind))
            KIND_EVAL: begin
                if (w.dust_ug > cfg_model.dust_high || w.gas_ppm > cfg_model.gas_high) begin
                    if (ctl_auto) begin
                        ctl_wanted = FAN_HIGH;
                        if (ctl_level != LVL_RED) beeps = BEEP_ALARM;
                    end
                    ctl_level = LVL_RED;
                end else if (w.dust_ug > cfg_model.dust_med || w.gas_ppm > cfg_model.gas_med) begin
                    if (ctl_auto) ctl_wanted = FAN_MID;
                    ctl_level = LVL_YELLOW;
                end else begin
                    if (ctl_auto) ctl_wanted = FAN_OFF;
                    ctl_level = LVL_GREEN;
                end
                // Step-ups and manual changes are immediate; step-downs from HIGH or MID wait out the dwell.
                if (ctl_wanted != ctl_applied) begin
                    if (!ctl_auto || ctl_wanted > ctl_applied) step = 1'b1;
                    else if (ctl_applied == FAN_HIGH) step = ctl_dwell >= cfg_model.hold_top_ms;
                    else if (ctl_applied == FAN_MID) step = ctl_dwell >= cfg_model.hold_mid_ms;
                    else step = 1'b1;
                    if (step) begin
                        ctl_applied = ctl_wanted;
                        ctl_dwell = '0;
                        case (ctl_applied)
                            FAN_OFF: ctl_duty = DUTY_OFF;
                            FAN_LOW: ctl_duty = DUTY_LOW;
                            FAN_MID: ctl_duty = DUTY_MID;
                            default: ctl_duty = DUTY_HIGH;
                        endcase
                    end
                end
                // A low reservoir always wins; otherwise auto mode follows the climate.
                if (w.tank_low) begin
                    ctl_mist = 1'b0;
                end else if (ctl_auto) begin
                    ctl_mist = ($signed(w.temp_tenths) > $signed(cfg_model.temp_high)) ||
                               (w.hum_tenths < cfg_model.hum_low && w.hum_tenths != 10'd0);
                end
            end
            KIND_SET_AUTO: begin
                ctl_auto = (w.value != 2'd0);
                if (ctl_auto) begin
                    beeps = BEEP_AUTO;
                    ctl_wanted = FAN_OFF;
                    ctl_applied = FAN_OFF;
                    ctl_duty = DUTY_OFF;
                end else begin
                    beeps = BEEP_ACK;
                end
            end
            KIND_SET_FAN: begin
                if (!ctl_auto) begin
                    ctl_wanted = w.value;
                    beeps = BEEP_ACK;
                end
            end
            default: begin
                if (!ctl_auto) begin
                    ctl_mist = (w.value != 2'd0);
                    beeps = BEEP_ACK;
                end
            end
        endcase
        r.pollution_level = ctl_level;
        r.fan_speed = ctl_applied;
        r.fan_relay = (ctl_applied != FAN_OFF);
        r.fan_duty = ctl_duty;
        r.mist_relay = ctl_mist;
        r.beeps = beeps;
        r.auto_flag = ctl_auto;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp, input logic [7:0] act);
        if (act !== exp) begin
            $error("%s: expected %0d, actual %0d", name, exp, act);
            mismatches++;
        end
    endtask

    // Accepted words on all three ports: config writes and inputs feed the model,
    // output words are checked against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_item   seen;
        t_result predicted;
        t_result oldest;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DUST_HIGH: cfg_model.dust_high = i_cfg_data;
                    CFG_DUST_MED:  cfg_model.dust_med = i_cfg_data;
                    CFG_GAS_HIGH:  cfg_model.gas_high = i_cfg_data;
                    CFG_GAS_MED:   cfg_model.gas_med = i_cfg_data;
                    CFG_TEMP_HIGH: cfg_model.temp_high = i_cfg_data[11:0];
                    CFG_HUM_LOW:   cfg_model.hum_low = i_cfg_data[9:0];
                    CFG_HOLD_TOP:  cfg_model.hold_top_ms = i_cfg_data;
                    default:       cfg_model.hold_mid_ms = i_cfg_data;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                seen = '{i_kind, i_value, i_dust_ug, i_gas_ppm, i_temp_tenths,
                         i_hum_tenths, i_tank_low, i_elapsed_ms};
                predicted = predict_status(seen);
                pending_status.push_back(word_typed ? word_status : predicted);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_status.size() == 0) begin
                    $error("output word arrived with no expectation waiting");
                    mismatches++;
                end else begin
                    oldest = pending_status.pop_front();
                    compare_field("pollution_level", 8'(oldest.pollution_level),
                                  8'(o_pollution_level));
                    compare_field("fan_speed", 8'(oldest.fan_speed), 8'(o_fan_speed));
                    compare_field("fan_relay", 8'(oldest.fan_relay), 8'(o_fan_relay));
                    compare_field("fan_duty", oldest.fan_duty, o_fan_duty);
                    compare_field("mist_relay", 8'(oldest.mist_relay), 8'(o_mist_relay));
                    compare_field("beeps", 8'(oldest.beeps), 8'(o_beeps));
                    compare_field("auto_flag", 8'(oldest.auto_flag), 8'(o_auto_flag));
                end
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int held;
        forever begin
            @(negedge i_clk);
            if (choke_request) begin
                i_out_ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge i_clk);
                choke_request = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic t_item evaluate(input int dust, input int gas, input int temp,
                                       input int hum, input bit water, input int elapsed);
        t_item w;
        w.kind = KIND_EVAL;
        w.value = 2'd0;
        w.dust_ug = dust[15:0];
        w.gas_ppm = gas[15:0];
        w.temp_tenths = temp[11:0];
        w.hum_tenths = hum[9:0];
        w.tank_low = water;
        w.elapsed_ms = elapsed[15:0];
        return w;
    endfunction

    function automatic t_item command(input t_kind kind, input int value, input int elapsed);
        t_item w;
        w = '0;
        w.kind = kind;
        w.value = value[1:0];
        w.elapsed_ms = elapsed[15:0];
        return w;
    endfunction

    // Random word: mostly evaluations near the current thresholds, with commands mixed in.
    function automatic t_item random_word();
        t_item       w;
        int unsigned pick;
        int          dust;
        int          gas;
        int          temp;
        int          hum;
        pick = $urandom_range(99);
        if (pick < 76) w.kind = KIND_EVAL;
        else if (pick < 83) w.kind = KIND_SET_FAN;
        else if (pick < 90) w.kind = KIND_SET_MIST;
        else w.kind = KIND_SET_AUTO;
        // At least half of the mode commands switch to manual so that both modes get exercised.
        w.value = (w.kind == KIND_SET_AUTO && $urandom_range(1) == 0) ? 2'd0 : 2'($urandom);
        case ($urandom_range(3))
            0: dust = int'(cfg_model.dust_med) + $urandom_range(4) - 2;
            1: dust = int'(cfg_model.dust_high) + $urandom_range(4) - 2;
            2: dust = $urandom_range(300);
            default: dust = $urandom;
        endcase
        case ($urandom_range(3))
            0: gas = int'(cfg_model.gas_med) + $urandom_range(4) - 2;
            1: gas = int'(cfg_model.gas_high) + $urandom_range(4) - 2;
            2: gas = $urandom_range(1200);
            default: gas = $urandom;
        endcase
        case ($urandom_range(9))
            0, 1, 2: temp = int'($signed(cfg_model.temp_high)) + $urandom_range(4) - 2;
            9: temp = $urandom;
            default: temp = $urandom_range(TEMP_MAX - TEMP_MIN) + TEMP_MIN;
        endcase
        case ($urandom_range(9))
            0, 1, 2: hum = int'(cfg_model.hum_low) + $urandom_range(4) - 2;
            3: hum = 0;
            9: hum = $urandom;
            default: hum = $urandom_range(HUM_MAX);
        endcase
        w.dust_ug = dust[15:0];
        w.gas_ppm = gas[15:0];
        w.temp_tenths = temp[11:0];
        w.hum_tenths = hum[9:0];
        w.tank_low = ($urandom_range(5) == 0);
        case ($urandom_range(3))
            0: w.elapsed_ms = 16'($urandom_range(40));
            1: w.elapsed_ms = 16'($urandom_range(3000));
            2: w.elapsed_ms = 16'($urandom_range(40000));
            default: w.elapsed_ms = 16'($urandom);
        endcase
        return w;
    endfunction

    // Offers one word after a random gap and holds it until it is taken.
    task automatic send_word(input t_item w, input logic typed, input t_result status);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= w.kind;
        i_value <= w.value;
        i_dust_ug <= w.dust_ug;
        i_gas_ppm <= w.gas_ppm;
        i_temp_tenths <= w.temp_tenths;
        i_hum_tenths <= w.hum_tenths;
        i_tank_low <= w.tank_low;
        i_elapsed_ms <= w.elapsed_ms;
        word_typed <= typed;
        word_status <= status;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(random_word(), 1'b0, '0);
    endtask

    // Stops offering words and waits until every expected word has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_thresholds(input logic [15:0] dust_high, input logic [15:0] dust_med,
                                      input logic [15:0] gas_high, input logic [15:0] gas_med,
                                      input logic [15:0] temp_high, input logic [15:0] hum_low,
                                      input logic [15:0] hold_top, input logic [15:0] hold_mid);
        write_register(CFG_DUST_HIGH, dust_high);
        write_register(CFG_DUST_MED, dust_med);
        write_register(CFG_GAS_HIGH, gas_high);
        write_register(CFG_GAS_MED, gas_med);
        write_register(CFG_TEMP_HIGH, temp_high);
        write_register(CFG_HUM_LOW, hum_low);
        write_register(CFG_HOLD_TOP, hold_top);
        write_register(CFG_HOLD_MID, hold_mid);
    endtask

    task automatic program_random_thresholds();
        int temp;
        temp = $urandom_range(TEMP_MAX - TEMP_MIN) + TEMP_MIN;
        program_thresholds(16'($urandom_range(1000)), 16'($urandom_range(500)),
                           16'($urandom_range(2000)), 16'($urandom_range(1000)),
                           temp[15:0], 16'($urandom_range(HUM_MAX)),
                           16'($urandom_range(40000)), 16'($urandom_range(40000)));
    endtask

    initial begin : stimulus
        // Known values on every input before reset releases.
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_kind = KIND_EVAL;
        i_value = '0;
        i_dust_ug = '0;
        i_gas_ppm = '0;
        i_temp_tenths = '0;
        i_hum_tenths = '0;
        i_tank_low = 1'b0;
        i_elapsed_ms = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_DUST_HIGH;
        i_cfg_data = '0;
        word_typed = 1'b0;
        word_status = '0;
        sender_idle_pct = 36;
        receiver_idle_pct = 36;
        choke_request = 1'b0;
        mismatches = 0;
        cycles = 0;

        // Model starts from the reset thresholds and state.
        cfg_model = '{RST_DUST_HIGH, RST_DUST_MED, RST_GAS_HIGH, RST_GAS_MED,
                      RST_TEMP_HIGH, RST_HUM_LOW, RST_HOLD_TOP, RST_HOLD_MID};
        ctl_auto = 1'b1;
        ctl_wanted = FAN_OFF;
        ctl_applied = FAN_OFF;
        ctl_dwell = '0;
        ctl_level = LVL_GREEN;
        ctl_mist = 1'b0;
        ctl_duty = DUTY_OFF;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: field extremes, threshold edges, dwell holds and every command.
        directed_rows.push_back(t_row'{evaluate(0, 0, 0, 0, 0, 0), 1'b1,
            t_result'{LVL_GREEN, FAN_OFF, 1'b0, DUTY_OFF, 1'b0, BEEP_NONE, 1'b1}});
        directed_rows.push_back(t_row'{evaluate(65535, 0, TEMP_MAX, HUM_MAX, 0, 100), 1'b1,
            t_result'{LVL_RED, FAN_HIGH, 1'b1, DUTY_HIGH, 1'b1, BEEP_ALARM, 1'b1}});
        // The dwell counter reaches its maximum here; the low reservoir forces mist off.
        directed_rows.push_back(t_row'{evaluate(0, 65535, TEMP_MIN, HUM_MAX, 1, 65535), 1'b1,
            t_result'{LVL_RED, FAN_HIGH, 1'b1, DUTY_HIGH, 1'b0, BEEP_NONE, 1'b1}});
        directed_rows.push_back(t_row'{evaluate(76, 0, TEMP_MIN, 599, 0, 0), 1'b1,
            t_result'{LVL_YELLOW, FAN_MID, 1'b1, DUTY_MID, 1'b1, BEEP_NONE, 1'b1}});
        // Readings equal to a threshold are not above it; the dwell is one short.
        directed_rows.push_back(t_row'{evaluate(75, 400, 350, 600, 0, 19999), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(0, 0, 0, 0, 0, 1), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(151, 0, 0, 0, 0, 10), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(0, 801, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(0, 401, -1, 1, 0, 100), 1'b0, '0});
        // Fan and mist commands are ignored in auto mode; auto on while on resets the fan.
        directed_rows.push_back(t_row'{command(KIND_SET_FAN, 1, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_MIST, 1, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_AUTO, 2, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_AUTO, 0, 5), 1'b0, '0});
        // Manual mode: wanted level applies at the next evaluation, mist is left alone but for a low tank.
        directed_rows.push_back(t_row'{command(KIND_SET_FAN, 3, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(0, 0, TEMP_MAX, 100, 0, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_FAN, 0, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(65535, 65535, 0, 0, 0, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_MIST, 2, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(0, 0, 0, 0, 0, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(0, 0, 0, 0, 1, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_MIST, 0, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_FAN, 2, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(80, 0, 0, 0, 0, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_FAN, 1, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{evaluate(0, 0, 0, 0, 0, 5), 1'b0, '0});
        directed_rows.push_back(t_row'{command(KIND_SET_AUTO, 3, 65535), 1'b0, '0});
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].status);

        // Reset thresholds, random traffic.
        run_random(250);
        wait_for_results();

        // Lowest settings, with a stretch of back-to-back traffic on both sides.
        program_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'(TEMP_MIN), 16'd0, 16'd0, 16'd0);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        run_random(200);
        wait_for_results();

        // Highest settings; the output side holds off long enough to back up the input.
        program_thresholds(MS_MAX, MS_MAX, MS_MAX, MS_MAX, 16'(TEMP_MAX), 16'(HUM_MAX),
                           MS_MAX, MS_MAX);
        sender_idle_pct = 36;
        receiver_idle_pct = 36;
        choke_request = 1'b1;
        run_random(200);
        wait_for_results();

        // Two random settings.
        program_random_thresholds();
        run_random(220);
        wait_for_results();
        program_random_thresholds();
        run_random(230);
        wait_for_results();

        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
